>>> rtl/bds2x2_pkg.sv
// Package with the constants, register codes and size helper of the 2x2 box downsampler.
package bds2x2_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int MAX_WIDTH      = 4096;
    localparam int MAX_HEIGHT     = 4096;
    localparam int CFG_BITS       = 13;
    localparam int CFG_IDX_BITS   = 2;
    localparam int POS_BITS       = $clog2(MAX_WIDTH > MAX_HEIGHT ? MAX_WIDTH : MAX_HEIGHT);
    localparam int LINE_DEPTH     = (MAX_WIDTH + 1) / 2;
    localparam int LINE_ADDR_BITS = $clog2(LINE_DEPTH);
    localparam int PAIR_BITS      = SAMPLE_BITS + 1;
    localparam int SUM_BITS       = SAMPLE_BITS + 2;

    typedef logic [CFG_IDX_BITS-1:0] t_cfg_index;
    typedef logic [CFG_BITS-1:0]     t_cfg_data;
    typedef logic [POS_BITS-1:0]     t_pos;
    typedef logic [SAMPLE_BITS-1:0]  t_sample;
    typedef logic [PAIR_BITS-1:0]    t_pair;
    typedef logic [SUM_BITS-1:0]     t_sum;

    localparam t_cfg_index REG_FRAME_WIDTH  = t_cfg_index'(0);
    localparam t_cfg_index REG_FRAME_HEIGHT = t_cfg_index'(1);

    // Turns a configured size into the index of its last position, with 0 read as 1 and sizes above top read as top.
    function automatic t_pos last_index(input t_cfg_data size, input int top);
        t_cfg_data clamped;
        clamped = size;
        if (size == '0) begin
            clamped = t_cfg_data'(1);
        end else if (int'(size) > top) begin
            clamped = t_cfg_data'(top);
        end
        return t_pos'(clamped - t_cfg_data'(1));
    endfunction

endpackage

>>> rtl/box_downsample_2x2.sv
// Top level of the 2x2 box downsampler with its pair-sum line store.
//
//  Channel   Direction  Signals                               Contents
//  s_axis    in         tvalid tready tdata[15:0]             source sample
//  m_axis    out        tvalid tready tdata[15:0] tlast       mean, frame_last
//  cfg       in         valid ready index[1:0] data[12:0]     frame width, frame height
//
// Samples are taken one per clock while s_axis_tready is high; each result is registered.
// The line store has one read and one write port, each used at most once a clock.
// Reset clears the counters and restores both sizes to 4096; the line store is not cleared.
// A stalled output lowers s_axis_tready in the same clock once the middle stage also holds
// an item.
module box_downsample_2x2 (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [15:0]                s_axis_tdata,   // [15:0] sample
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [15:0]                m_axis_tdata,   // [15:0] mean
    output logic                       m_axis_tlast,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  bds2x2_pkg::t_cfg_index     i_cfg_index,
    input  bds2x2_pkg::t_cfg_data      i_cfg_data
);
    import bds2x2_pkg::*;

    t_pos    r_col_last, r_row_last;
    t_pos    r_col, r_row, n_col, n_row;
    t_sample r_held;
    logic    r_s1_valid, r_s1_use_line, r_s1_last;
    t_pair   r_s1_pair;
    logic    r_out_valid, r_out_last;
    t_sample r_out_mean;
    t_pair   r_line_rd;
    t_pair   line_mem [LINE_DEPTH];

    t_sample               sample;
    logic                  accept, out_fire, s1_move;
    logic                  last_col, last_row, have_pair, emit;
    logic                  line_we, line_re;
    t_pair                 pair;
    t_sum                  sum, sum_rnd;
    logic [LINE_ADDR_BITS-1:0] line_addr;

    assign sample    = s_axis_tdata;
    assign out_fire  = r_out_valid && m_axis_tready;
    assign s1_move   = r_s1_valid && (!r_out_valid || out_fire);
    assign s_axis_tready = !r_s1_valid || s1_move;
    assign accept    = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready = 1'b1;

    assign last_col  = r_col >= r_col_last;
    assign last_row  = r_row >= r_row_last;
    assign have_pair = r_col[0] || last_col;
    assign pair      = r_col[0] ? (t_pair'(r_held) + t_pair'(sample))
                                : (t_pair'(sample) + t_pair'(sample));
    assign emit      = have_pair && (r_row[0] || last_row);
    assign line_we   = accept && have_pair && !r_row[0] && !last_row;
    assign line_re   = accept && have_pair && r_row[0];
    assign line_addr = r_col[LINE_ADDR_BITS:1];

    always_comb begin
        n_col = r_col + t_pos'(1);
        n_row = r_row;
        if (last_col) begin
            n_col = '0;
            n_row = last_row ? '0 : r_row + t_pos'(1);
        end
    end

    assign sum     = r_s1_use_line ? (t_sum'(r_line_rd) + t_sum'(r_s1_pair))
                                   : {r_s1_pair, 1'b0};
    assign sum_rnd = sum + t_sum'(2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_last <= last_index(t_cfg_data'(MAX_WIDTH), MAX_WIDTH);
            r_row_last <= last_index(t_cfg_data'(MAX_HEIGHT), MAX_HEIGHT);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_FRAME_WIDTH:  r_col_last <= last_index(i_cfg_data, MAX_WIDTH);
                REG_FRAME_HEIGHT: r_row_last <= last_index(i_cfg_data, MAX_HEIGHT);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_held <= '0;
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
            if (!r_col[0] && !last_col) begin
                r_held <= sample;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (line_we) begin
            line_mem[line_addr] <= pair;
        end
        if (line_re) begin
            r_line_rd <= line_mem[line_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= emit;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pair     <= pair;
            r_s1_use_line <= r_row[0];
            r_s1_last     <= last_col && last_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_move) begin
            r_out_valid <= 1'b1;
        end else if (out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_mean <= sum_rnd[SUM_BITS-1:2];
            r_out_last <= r_s1_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_mean;
    assign m_axis_tlast  = r_out_last;

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_out_valid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input taken while the result pipeline is stalled");

    a_emit_reaches_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && emit) |=> r_s1_valid)
        else $error("emitting item did not enter the result stage");

    a_row_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && last_col) |=> (r_col == '0))
        else $error("column count did not wrap at the end of a row");

    a_stage_moves_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_move |=> r_out_valid)
        else $error("result lost between stage and output register");

    a_line_ports_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(line_we && line_re))
        else $error("line store read and written by the same item");

endmodule
